[src/frdr_pkg.sv]
package frdr_pkg;

    // Fixed-point constants
    localparam int unsigned ETA_W   = 16;
    localparam int unsigned COS_W   = 16;
    localparam int unsigned REFL_W  = 16;
    localparam logic [15:0] ONE_Q15 = 16'h8000;
    localparam logic [15:0] ETA_RST = 16'h1000;

    // Register indexes
    localparam logic REG_ETA_FRONT = 1'b0;
    localparam logic REG_ETA_BACK  = 1'b1;

    // Pipeline geometry
    localparam int unsigned DIVQ_N  = 30;              // quotient bits, sine ratio
    localparam int unsigned SQRT_N  = 16;              // root digits
    localparam int unsigned RATQ_N  = 16;              // quotient bits, amplitude ratios
    localparam int unsigned ST_TIR  = 4;               // compare stage, divider entry
    localparam int unsigned ST_SQ0  = ST_TIR + DIVQ_N + 1;
    localparam int unsigned ST_MUL  = ST_SQ0 + SQRT_N + 1;
    localparam int unsigned ST_REM  = ST_MUL + 2;
    localparam int unsigned ST_SQR  = ST_REM + RATQ_N + 1;
    localparam int unsigned LATENCY = ST_SQR + 1;

    // Values that travel alongside every stage
    typedef struct packed {
        logic        valid;
        logic        tir;
        logic [15:0] c;
        logic [15:0] ei;
        logic [15:0] et;
    } t_side;

endpackage

[src/fresnel_dielectric_reflectance.sv]
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+--------------------------------
// item in   | i_cos_theta_in                                | i_start && !o_busy
// result    | o_reflectance, o_total_internal               | o_valid, one cycle, no stall
// config    | i_cfg_index, i_cfg_wdata                      | i_cfg_we
//
// One item enters every cycle; o_busy is never raised.
// Each result passes through the 30-step divider for the transmitted sine, the
// 16-step square root and the 16-step ratio dividers.
// Reset clears the valid bits of every stage and loads both indices with ETA_RST.
// The receiver cannot stall, so the pipeline never holds.
module fresnel_dielectric_reflectance
    import frdr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [COS_W-1:0]     i_cos_theta_in,
    output logic                 o_valid,
    output logic [REFL_W-1:0]    o_reflectance,
    output logic                 o_total_internal,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [ETA_W-1:0]     i_cfg_wdata
);

    logic [ETA_W-1:0] r_eta_front, r_eta_back;
    t_side            r_sb [1:ST_SQR];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_front <= ETA_RST;
            r_eta_back  <= ETA_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_ETA_FRONT) r_eta_front <= i_cfg_wdata;
            if (i_cfg_index == REG_ETA_BACK)  r_eta_back  <= i_cfg_wdata;
        end
    end

    assign o_busy = 1'b0;

    // Stage 1: fold the sign, swap indices for the back side
    logic        in_neg, in_entering;
    t_side       n_sb1;
    always_comb begin
        in_neg         = i_cos_theta_in[COS_W-1];
        in_entering    = !in_neg && (i_cos_theta_in != '0);
        n_sb1.valid    = i_start;
        n_sb1.tir      = 1'b0;
        n_sb1.c        = in_neg ? (~i_cos_theta_in + 16'd1) : i_cos_theta_in;
        n_sb1.ei       = in_entering ? r_eta_front : r_eta_back;
        n_sb1.et       = in_entering ? r_eta_back  : r_eta_front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sb[1].valid <= 1'b0;
        else          r_sb[1]       <= n_sb1;
    end

    // Advance the sideband; the compare stage adds the TIR flag
    logic [61:0] r_lhs;
    logic [31:0] r_et2_c;
    for (genvar k = 2; k <= ST_SQR; k++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sb[k].valid <= 1'b0;
            end else if (k == ST_TIR) begin
                r_sb[k] <= {r_sb[k-1].valid, (r_lhs >= {r_et2_c, 30'd0}),
                            r_sb[k-1].c, r_sb[k-1].ei, r_sb[k-1].et};
            end else begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // Stage 2: squares
    logic [30:0] r_cc;
    logic [31:0] r_ei2, r_et2_b;
    always_ff @(posedge i_clk) begin
        r_cc    <= 31'(32'(r_sb[1].c) * 32'(r_sb[1].c));
        r_ei2   <= 32'(r_sb[1].ei) * 32'(r_sb[1].ei);
        r_et2_b <= 32'(r_sb[1].et) * 32'(r_sb[1].et);
    end

    // Stage 3: scaled incident sine squared
    always_ff @(posedge i_clk) begin
        r_lhs   <= 62'(r_ei2) * 62'(31'h4000_0000 - r_cc);
        r_et2_c <= r_et2_b;
    end

    // Stage 4 and on: restoring division, one quotient bit a stage
    logic [61:0] r_dv_rem [0:DIVQ_N];
    logic [31:0] r_dv_den [0:DIVQ_N];
    logic [29:0] r_dv_q   [0:DIVQ_N];
    always_ff @(posedge i_clk) begin
        r_dv_rem[0] <= r_lhs;
        r_dv_den[0] <= r_et2_c;
        r_dv_q[0]   <= '0;
    end
    for (genvar k = 0; k < DIVQ_N; k++) begin : g_dv
        localparam int unsigned SH = DIVQ_N - 1 - k;
        logic [61:0] dv_sub;
        logic        dv_ge;
        always_comb begin
            dv_sub = 62'(r_dv_den[k]) << SH;
            dv_ge  = r_dv_rem[k] >= dv_sub;
        end
        always_ff @(posedge i_clk) begin
            r_dv_rem[k+1]     <= dv_ge ? (r_dv_rem[k] - dv_sub) : r_dv_rem[k];
            r_dv_den[k+1]     <= r_dv_den[k];
            r_dv_q[k+1]       <= r_dv_q[k] | (30'(dv_ge) << SH);
        end
    end

    // Square root of one minus the transmitted sine squared, one digit a stage
    logic [30:0] r_sq_v [0:SQRT_N];
    logic [31:0] r_sq_r [0:SQRT_N];
    always_ff @(posedge i_clk) begin
        r_sq_v[0] <= 31'h4000_0000 - 31'(r_dv_q[DIVQ_N]);
        r_sq_r[0] <= '0;
    end
    for (genvar j = 0; j < SQRT_N; j++) begin : g_sq
        localparam logic [31:0] BIT = 32'd1 << (30 - 2 * j);
        logic [32:0] sq_try;
        logic        sq_ge;
        always_comb begin
            sq_try = 33'(r_sq_r[j]) + 33'(BIT);
            sq_ge  = 33'(r_sq_v[j]) >= sq_try;
        end
        always_ff @(posedge i_clk) begin
            r_sq_v[j+1] <= sq_ge ? 31'(33'(r_sq_v[j]) - sq_try) : r_sq_v[j];
            r_sq_r[j+1] <= sq_ge ? ((r_sq_r[j] >> 1) + BIT) : (r_sq_r[j] >> 1);
        end
    end

    // Amplitude terms: lane 0 parallel, lane 1 perpendicular
    logic [15:0] ct;
    logic [31:0] r_x [0:1];
    logic [31:0] r_y [0:1];
    assign ct = r_sq_r[SQRT_N][15:0];
    always_ff @(posedge i_clk) begin
        r_x[0] <= 32'(r_sb[ST_MUL-1].et) * 32'(r_sb[ST_MUL-1].c);
        r_y[0] <= 32'(r_sb[ST_MUL-1].ei) * 32'(ct);
        r_x[1] <= 32'(r_sb[ST_MUL-1].ei) * 32'(r_sb[ST_MUL-1].c);
        r_y[1] <= 32'(r_sb[ST_MUL-1].et) * 32'(ct);
    end

    // Per lane: difference and sum, rounded dividend, then division
    logic [46:0] r_rd_rem [0:RATQ_N][0:1];
    logic [31:0] r_rd_den [0:RATQ_N][0:1];
    logic [15:0] r_rd_q   [0:RATQ_N][0:1];
    logic [31:0] r_num [0:1];
    logic [31:0] r_den [0:1];
    logic [15:0] ratio [0:1];
    logic [31:0] r_sqr [0:1];
    for (genvar l = 0; l < 2; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            r_den[l]       <= r_x[l] + r_y[l];
            r_num[l]       <= (r_x[l] >= r_y[l]) ? (r_x[l] - r_y[l]) : (r_y[l] - r_x[l]);
            r_rd_rem[0][l] <= {r_num[l], 15'd0} + 47'(r_den[l] >> 1);
            r_rd_den[0][l] <= r_den[l];
            r_rd_q[0][l]   <= '0;
        end
        for (genvar k = 0; k < RATQ_N; k++) begin : g_rd
            localparam int unsigned SH = RATQ_N - 1 - k;
            logic [46:0] rd_sub;
            logic        rd_ge;
            always_comb begin
                rd_sub = 47'(r_rd_den[k][l]) << SH;
                rd_ge  = r_rd_rem[k][l] >= rd_sub;
            end
            always_ff @(posedge i_clk) begin
                r_rd_rem[k+1][l]     <= rd_ge ? (r_rd_rem[k][l] - rd_sub) : r_rd_rem[k][l];
                r_rd_den[k+1][l]     <= r_rd_den[k][l];
                r_rd_q[k+1][l]       <= r_rd_q[k][l] | (16'(rd_ge) << SH);
            end
        end
        // Take a zero denominator as 1.0, clip at 1.0, then square
        always_comb begin
            if (r_rd_den[RATQ_N][l] == '0 || r_rd_q[RATQ_N][l] > ONE_Q15) ratio[l] = ONE_Q15;
            else                                                          ratio[l] = r_rd_q[RATQ_N][l];
        end
        always_ff @(posedge i_clk) begin
            r_sqr[l] <= 32'(ratio[l]) * 32'(ratio[l]);
        end
    end

    // Output stage: mean of squares, saturate, override on TIR
    logic [32:0] sum_sq;
    logic [16:0] mean;
    logic        r_valid, r_tir;
    logic [15:0] r_refl;
    always_comb begin
        sum_sq = 33'(r_sqr[0]) + 33'(r_sqr[1]) + 33'd32768;
        mean   = sum_sq[32:16];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= r_sb[ST_SQR].valid;
        r_tir <= r_sb[ST_SQR].tir;
        if (r_sb[ST_SQR].tir || mean > 17'(ONE_Q15)) r_refl <= ONE_Q15;
        else                                         r_refl <= mean[15:0];
    end

    assign o_valid          = r_valid;
    assign o_reflectance    = r_refl;
    assign o_total_internal = r_tir;

endmodule

[src/frdr_chk.sv]
module frdr_chk
    import frdr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_valid,
    input logic [REFL_W-1:0] o_reflectance,
    input logic              o_total_internal
);

    // A result only follows an item taken out of reset
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy && i_rst_n, LATENCY))
        else $error("result without matching item");

    // Total internal reflection reports exactly 1.0
    a_tir_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_total_internal) |-> (o_reflectance == ONE_Q15))
        else $error("TIR result not 1.0");

    // Reflectance never exceeds 1.0
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reflectance <= ONE_Q15))
        else $error("reflectance above 1.0");

endmodule

bind fresnel_dielectric_reflectance frdr_chk u_frdr_chk (.*);
